// ===== hw/rtl/fqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_pkg: shared types and codes for the queue with indexed delete
// Operation and status codes, beat payload structs, per-cell control.
// ----------------------------------------------------------------------------
package fqd_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [4:0]         position;
  } fqd_cmd_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } fqd_rsp_t;

  typedef struct packed {
    logic load;   // take the pushed value
    logic shift;  // take the neighbor's value
  } fqd_cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fifo_queue_with_indexed_delete.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_delete: bounded queue with push, pop, delete, clear
// Row of cells, head in cell 0; pop and delete close the gap by shifting upper cells down.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the beat is taken on any edge where busy is
//   low. busy stays low: each cell decides from the count and the command
//   whether to hold, load the pushed value or take its upper neighbor, so
//   every operation finishes in the cycle it is taken.
//   The response appears on rsp with done high in the cycle after the
//   command beat. Throughput: one command per cycle.
//   Response: popped_value is the head on a good pop, 1 on an empty pop,
//   else 0; status flags empty pop, full push or bad delete position;
//   occupancy is the count after the command (low five bits).
//   Reset clears the count and done; cell contents are not cleared and
//   are never read before being written.
//   The receiver cannot stall: a response is valid for its one cycle only.
// ----------------------------------------------------------------------------
module fifo_queue_with_indexed_delete
  import fqd_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire fqd_cmd_t cmd,
  output logic          done,
  output fqd_rsp_t      rsp
);

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               done_next;
  fqd_rsp_t           rsp_next;
  logic               accept;
  logic               do_push;
  logic               do_shift;
  logic [CMPW-1:0]    shift_from;
  logic [CMPW-1:0]    pos_w;
  logic [CMPW-1:0]    count_w;
  logic signed [31:0] entries [QUEUE_DEPTH];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_w   = CMPW'(cmd.position);
  assign count_w = CMPW'(count);

  always_comb begin
    count_next = count;
    do_push    = 1'b0;
    do_shift   = 1'b0;
    shift_from = '0;
    rsp_next   = '0;
    if (accept) begin
      case (cmd.kind)
        KIND_PUSH: begin
          if (count == CW'(QUEUE_DEPTH)) begin
            rsp_next.status = ST_FULL;
          end else begin
            do_push    = 1'b1;
            count_next = count + CW'(1);
          end
        end
        KIND_POP: begin
          if (count == '0) begin
            rsp_next.popped_value = 32'sd1;
            rsp_next.status       = ST_EMPTY;
          end else begin
            rsp_next.popped_value = entries[0];
            do_shift              = 1'b1;
            count_next            = count - CW'(1);
          end
        end
        KIND_DELETE: begin
          if (pos_w == '0 || pos_w > count_w) begin
            rsp_next.status = ST_RANGE;
          end else begin
            do_shift   = 1'b1;
            shift_from = pos_w - CMPW'(1);
            count_next = count - CW'(1);
          end
        end
        KIND_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
    rsp_next.occupancy = 5'(count_next);
  end

  assign done_next = accept;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      fqd_cell_ctrl_t     ctrl;
      logic signed [31:0] upper;

      assign ctrl.load  = do_push && (count == CW'(gi));
      assign ctrl.shift = do_shift && (CMPW'(gi) >= shift_from);

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign upper = entries[gi];
      end else begin : g_mid
        assign upper = entries[gi+1];
      end

      fqd_cell u_cell (
        .clk            (clk),
        .ctrl           (ctrl),
        .push_value     (cmd.value),
        .neighbor_value (upper),
        .entry          (entries[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= done_next;
    end
  end

  // Response payload needs no reset; done qualifies it.
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("response missing after command beat");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (rsp.occupancy == 5'd0 && count == '0))
    else $error("empty pop with nonzero occupancy");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fqd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqd_cell: one storage cell of the queue chain
// Holds one entry; loads a pushed value or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module fqd_cell
  import fqd_pkg::*;
(
  input  wire logic               clk,
  input  wire fqd_cell_ctrl_t     ctrl,
  input  wire logic signed [31:0] push_value,
  input  wire logic signed [31:0] neighbor_value,
  output logic signed [31:0]      entry
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= neighbor_value;
    end else if (ctrl.load) begin
      entry <= push_value;
    end
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: command-level check of the queue with indexed delete
// Drives push, pop, delete and clear beats with random gaps. A scoreboard
// keeps its own copy of the queue and compares every response field.
// ----------------------------------------------------------------------------
module testbench;
  import fqd_pkg::*;

  localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
  localparam int RANDOM_BEATS = 1200;
  localparam int CALM_TAIL    = 150;

  class queue_scoreboard;
    logic signed [31:0] cells [DEPTH];
    int unsigned        held;
    fqd_rsp_t           pending [$];
    int                 failures;
    int                 checked;
    int                 status_seen [4];
    int unsigned        peak;

    function new();
      held     = 0;
      failures = 0;
      checked  = 0;
      peak     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Predict the response of one accepted command beat.
    function void note_command(fqd_cmd_t c);
      fqd_rsp_t r;
      r = '0;
      r.status = ST_OK;
      case (c.kind)
        KIND_PUSH: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            cells[held] = c.value;
            held++;
          end
        end
        KIND_POP: begin
          if (held == 0) begin
            r.popped_value = 32'sd1;
            r.status = ST_EMPTY;
          end else begin
            r.popped_value = cells[0];
            for (int i = 1; i < held; i++) cells[i-1] = cells[i];
            held--;
          end
        end
        KIND_DELETE: begin
          if (c.position == 5'd0 || c.position > held) begin
            r.status = ST_RANGE;
          end else begin
            // close the gap, keep the order
            for (int i = c.position; i < held; i++) cells[i-1] = cells[i];
            held--;
          end
        end
        default: begin
          held = 0;
        end
      endcase
      r.occupancy = 5'(held);
      if (held > peak) peak = held;
      pending.push_back(r);
    endfunction

    function void check_response(fqd_rsp_t got);
      fqd_rsp_t want;
      if (pending.size() == 0) begin
        $error("unexpected response beat: popped_value %0d status %0d occupancy %0d",
               got.popped_value, got.status, got.occupancy);
        failures++;
        return;
      end
      want = pending.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.popped_value !== want.popped_value) begin
        $error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        failures++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  fqd_cmd_t cmd   = '0;
  logic     done;
  fqd_rsp_t rsp;

  queue_scoreboard sb = new();

  fifo_queue_with_indexed_delete #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Check the response before noting the beat taken on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(rsp);
      if (start && !busy) sb.note_command(cmd);
    end
  end

  // Call on a rising edge; returns on the edge that takes the beat.
  task automatic send_command(input logic [1:0] kind, input logic signed [31:0] value,
                              input logic [4:0] position);
    fqd_cmd_t c;
    c.kind     = kind;
    c.value    = value;
    c.position = position;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int mode;
    int roll;
    int guard;
    logic [1:0] kind;
    logic [4:0] position;
    bit quiet_block;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-queue cases, extremes, fill to full, edge positions.
    send_command(KIND_POP, $urandom, 5'd5);
    send_command(KIND_DELETE, $urandom, 5'd1);
    send_command(KIND_CLEAR, $urandom, 5'd16);
    send_command(KIND_PUSH, 32'sh7FFF_FFFF, 5'd31);
    send_command(KIND_PUSH, 32'sh8000_0000, 5'd0);
    send_command(KIND_PUSH, 32'sd0, 5'd16);
    send_command(KIND_PUSH, -32'sd1, 5'd3);
    for (int i = 4; i < DEPTH; i++) send_command(KIND_PUSH, $urandom, 5'($urandom));
    send_command(KIND_PUSH, 32'sh1234_5678, 5'd1);
    send_command(KIND_DELETE, $urandom, 5'd16);
    send_command(KIND_DELETE, $urandom, 5'd16);
    send_command(KIND_DELETE, $urandom, 5'd0);
    send_command(KIND_DELETE, $urandom, 5'd2);
    send_command(KIND_DELETE, $urandom, 5'd7);
    send_command(KIND_POP, $urandom, 5'd9);
    send_command(KIND_CLEAR, $urandom, 5'd4);
    send_command(KIND_POP, -32'sd1, 5'd16);
    send_command(KIND_DELETE, $urandom, 5'd0);

    // Random: blocks of 32 beats biased to fill, drain or stay balanced.
    mode = 0;
    quiet_block = 1'b0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 32 == 0) begin
        mode = $urandom_range(0, 2);
        quiet_block = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        0: kind = (roll < 65) ? KIND_PUSH : (roll < 80) ? KIND_POP :
                  (roll < 97) ? KIND_DELETE : KIND_CLEAR;
        1: kind = (roll < 20) ? KIND_PUSH : (roll < 65) ? KIND_POP :
                  (roll < 97) ? KIND_DELETE : KIND_CLEAR;
        default: kind = (roll < 40) ? KIND_PUSH : (roll < 70) ? KIND_POP :
                        (roll < 97) ? KIND_DELETE : KIND_CLEAR;
      endcase
      // favor low positions, which are in range more often
      roll = $urandom_range(0, 9);
      if (roll < 5) position = 5'($urandom_range(1, 4));
      else if (roll < 9) position = 5'($urandom_range(0, 16));
      else position = 5'd0;
      send_command(kind, pick_value(), position);
      if (n < RANDOM_BEATS - CALM_TAIL && !quiet_block && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 11));
    end
    start <= 1'b0;

    guard = 0;
    while (sb.pending.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected responses never arrived", sb.pending.size());
      sb.failures++;
    end

    $display("checked %0d responses: %0d ok, %0d empty pops, %0d full pushes, %0d bad deletes",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE]);
    $display("peak occupancy %0d of %0d, %0d mismatches", sb.peak, DEPTH, sb.failures);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== fifo_queue_with_indexed_delete.f =====
hw/rtl/fqd_pkg.sv
hw/rtl/fqd_cell.sv
hw/rtl/fifo_queue_with_indexed_delete.sv
bench/testbench.sv
